// ===== src/lsugm_pkg.sv =====
// ----------------------------------------------------------------------------
// lsugm_pkg
// shared types and constants of the word load/store unit with gpio map
// ----------------------------------------------------------------------------
package lsugm_pkg;

   // byte memory, split into four byte lanes of one row per word
   localparam int unsigned MEM_BYTES = 65536;
   localparam int unsigned MEM_ROWS  = (MEM_BYTES + 3) / 4;
   localparam int unsigned ROW_W     = $clog2(MEM_ROWS);
   localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(MEM_ROWS - 1);
   // highest address at which a whole word still fits
   localparam logic [31:0] MEM_LAST = 32'(MEM_BYTES - 4);

   // gpio address map
   localparam logic [31:0] GPIO_BANK0   = 32'h2020_0000;
   localparam logic [31:0] GPIO_BANK1   = 32'h2020_0004;
   localparam logic [31:0] GPIO_BANK2   = 32'h2020_0008;
   localparam logic [31:0] GPIO_PIN_ON  = 32'h2020_001C;
   localparam logic [31:0] GPIO_PIN_OFF = 32'h2020_0028;

   // barrel shift kinds
   localparam logic [1:0] SHIFT_LSL = 2'd0;
   localparam logic [1:0] SHIFT_LSR = 2'd1;
   localparam logic [1:0] SHIFT_ASR = 2'd2;
   localparam logic [1:0] SHIFT_ROR = 2'd3;

   typedef enum logic [1:0] {
      STATUS_MEM  = 2'd0,
      STATUS_GPIO = 2'd1,
      STATUS_OOB  = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      ST_CLEAR = 3'b001,
      ST_RUN   = 3'b010,
      ST_READ  = 3'b100
   } state_type;

   // classified operation handed from front to back
   typedef struct packed {
      logic        is_load;
      logic        pre;
      logic [31:0] base;
      logic [31:0] sum;      // base plus or minus offset
      logic [31:0] store_value;
   } op_type;

   // result payload
   typedef struct packed {
      status_type  status;
      logic        load_valid;
      logic [31:0] load_data;
      logic        writeback_valid;
      logic [31:0] writeback_value;
   } rsp_type;

endpackage

// ===== src/load_store_unit_with_gpio_map_core.sv =====
// ----------------------------------------------------------------------------
// load_store_unit_with_gpio_map_core
// word load/store unit with a little-endian byte memory and a small gpio map
// ----------------------------------------------------------------------------
// usage:
//   req channel carries one decoded load or store with its register values;
//   rsp channel returns one result transfer per request, in order.
//   the front computes the offset (immediate or barrel-shifted rm) and the
//   base sum in the accepting cycle and parks the operation in a two-entry
//   queue; the back decodes the address and accesses four byte lanes.
// path: stores, gpio and out-of-bounds items pass the queue entry and the
//   result register before rsp; memory loads also pass the lane read register.
// throughput: one item per cycle while rsp is not held, except memory loads,
//   which also hold the back in ST_READ for the registered lane read.
// reset: the back sweeps every memory row to zero, one row per cycle, over
//   MEM_BYTES/4 rows (16384); req_tready stays low until it is done.
// stall: a held rsp transfer stalls the back; the queue keeps taking requests
//   until both entries are full, then req_tready drops.
// ----------------------------------------------------------------------------
module load_store_unit_with_gpio_map_core (
   input  logic         clock,
   input  logic         reset,

   input  logic         req_tvalid,
   output logic         req_tready,
   // fields from bit 0: add_offset, pre_index, offset_field[11:0],
   // base_value[31:0], store_value[31:0], rm_value[31:0], rs_value[31:0], zero pad
   input  logic [143:0] req_tdata,
   // fields from bit 0: req_type, offset_is_shifted_reg
   input  logic [1:0]   req_tuser,

   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // fields from bit 0: load_valid, load_data[31:0], writeback_valid,
   // writeback_value[31:0], zero pad
   output logic [71:0]  rsp_tdata,
   // fields from bit 0: status[1:0]
   output logic [1:0]   rsp_tuser
);

   lsugm_pkg::op_type  front_op;
   lsugm_pkg::op_type  q_op;
   lsugm_pkg::rsp_type rsp;
   logic               q_in_ready;
   logic               q_valid;
   logic               q_pop;
   logic               clear_done;

   // no requests taken while the memory is being cleared
   assign req_tready = q_in_ready && clear_done;

   lsugm_front u_front (
      .req_type              (req_tuser[0]),
      .offset_is_shifted_reg (req_tuser[1]),
      .add_offset            (req_tdata[0]),
      .pre_index             (req_tdata[1]),
      .offset_field          (req_tdata[13:2]),
      .base_value            (req_tdata[45:14]),
      .store_value           (req_tdata[77:46]),
      .rm_value              (req_tdata[109:78]),
      .rs_value              (req_tdata[141:110]),
      .op                    (front_op)
   );

   // decouples offset generation from the memory side
   lsugm_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid && clear_done),
      .in_ready  (q_in_ready),
      .in_op     (front_op),
      .out_valid (q_valid),
      .out_pop   (q_pop),
      .out_op    (q_op)
   );

   lsugm_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (q_valid),
      .q_pop      (q_pop),
      .q_op       (q_op),
      .clear_done (clear_done),
      .rsp_valid  (rsp_tvalid),
      .rsp_ready  (rsp_tready),
      .rsp        (rsp)
   );

   // result packing
   assign rsp_tdata = {6'd0, rsp.writeback_value, rsp.writeback_valid,
                       rsp.load_data, rsp.load_valid};
   assign rsp_tuser = rsp.status;

endmodule

// ===== src/lsugm_front.sv =====
// ----------------------------------------------------------------------------
// lsugm_front
// offset generation: immediate or barrel-shifted register, then add or subtract
// ----------------------------------------------------------------------------
module lsugm_front (
   input  logic                  req_type,
   input  logic                  offset_is_shifted_reg,
   input  logic                  add_offset,
   input  logic                  pre_index,
   input  logic [11:0]           offset_field,
   input  logic [31:0]           base_value,
   input  logic [31:0]           store_value,
   input  logic [31:0]           rm_value,
   input  logic [31:0]           rs_value,
   output lsugm_pkg::op_type     op
);

   logic [1:0]  shift_kind;
   logic [7:0]  amount;
   logic [4:0]  amt5;
   logic        amt_big;
   logic [31:0] shifted;
   logic [31:0] offset;
   logic [63:0] rot_pair;

   assign shift_kind = offset_field[6:5];
   assign amount     = offset_field[4] ? rs_value[7:0] : {3'b000, offset_field[11:7]};
   assign amt5       = amount[4:0];
   assign amt_big    = |amount[7:5];
   assign rot_pair   = {rm_value, rm_value} >> amt5;

   always_comb begin
      shifted = rm_value;
      if (amount != 8'd0) begin
         case (shift_kind)
            lsugm_pkg::SHIFT_LSL: shifted = amt_big ? 32'd0 : (rm_value << amt5);
            lsugm_pkg::SHIFT_LSR: shifted = amt_big ? 32'd0 : (rm_value >> amt5);
            lsugm_pkg::SHIFT_ASR: begin
               if (amt_big) begin
                  shifted = {32{rm_value[31]}};
               end else begin
                  shifted = 32'($signed(rm_value) >>> amt5);
               end
            end
            lsugm_pkg::SHIFT_ROR: shifted = rot_pair[31:0];
            default:              shifted = rm_value;
         endcase
      end
   end

   assign offset = offset_is_shifted_reg ? shifted : {20'd0, offset_field};

   // one adder serves both the pre-index address and the post-index writeback
   assign op.is_load     = req_type;
   assign op.pre         = pre_index;
   assign op.base        = base_value;
   assign op.sum         = add_offset ? (base_value + offset) : (base_value - offset);
   assign op.store_value = store_value;

endmodule

// ===== src/lsugm_queue.sv =====
// ----------------------------------------------------------------------------
// lsugm_queue
// two-entry queue between the front and the back
// ----------------------------------------------------------------------------
module lsugm_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  lsugm_pkg::op_type     in_op,
   output logic                  out_valid,
   input  logic                  out_pop,
   output lsugm_pkg::op_type     out_op
);

   lsugm_pkg::op_type entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       push;
   logic       pop;

   assign in_ready  = (count_ff != 2'd2);
   assign out_valid = (count_ff != 2'd0);
   assign out_op    = entry_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_pop && out_valid;

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= in_op;
      end
   end

endmodule

// ===== src/lsugm_back.sv =====
// ----------------------------------------------------------------------------
// lsugm_back
// address decode, four-lane byte memory with clearing pass, result register
// ----------------------------------------------------------------------------
module lsugm_back (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  q_valid,
   output logic                  q_pop,
   input  lsugm_pkg::op_type     q_op,
   output logic                  clear_done,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output lsugm_pkg::rsp_type    rsp
);

   localparam int unsigned RW = lsugm_pkg::ROW_W;

   lsugm_pkg::state_type state_ff, state_in;
   logic [RW-1:0]        clr_row_ff, clr_row_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   lsugm_pkg::rsp_type   rsp_ff, rsp_in;
   logic [1:0]           a0_ff, a0_in;

   logic [31:0]   addr;
   logic          in_mem;
   logic          is_rb;
   logic          is_pin;
   logic          out_free;
   logic          mem_we;
   logic          mem_re;
   logic [RW-1:0] row_base;
   logic [RW-1:0] row_next;
   logic [63:0]   wr_pair;
   logic [31:0]   wr_word;
   logic [31:0]   rd_word;
   logic [63:0]   rd_pair;
   logic [7:0]    lane_rdat [4];

   // decode of the access address
   assign addr     = q_op.pre ? q_op.sum : q_op.base;
   assign in_mem   = (addr <= lsugm_pkg::MEM_LAST);
   assign is_rb    = (addr == lsugm_pkg::GPIO_BANK0) || (addr == lsugm_pkg::GPIO_BANK1) ||
                     (addr == lsugm_pkg::GPIO_BANK2);
   assign is_pin   = (addr == lsugm_pkg::GPIO_PIN_ON) || (addr == lsugm_pkg::GPIO_PIN_OFF);
   assign out_free = !rsp_valid_ff || rsp_ready;

   assign row_base = addr[RW+1:2];
   assign row_next = row_base + RW'(1);

   // store word rotated so that byte i lands in lane (addr + i) mod 4
   assign wr_pair  = {q_op.store_value, q_op.store_value} << {addr[1:0], 3'b000};
   assign wr_word  = wr_pair[63:32];

   // loaded lanes rotated back into byte order
   assign rd_word  = {lane_rdat[3], lane_rdat[2], lane_rdat[1], lane_rdat[0]};
   assign rd_pair  = {rd_word, rd_word} >> {a0_ff, 3'b000};

   always_comb begin
      state_in     = state_ff;
      clr_row_in   = clr_row_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      a0_in        = a0_ff;
      q_pop        = 1'b0;
      mem_we       = 1'b0;
      mem_re       = 1'b0;
      case (state_ff)
         lsugm_pkg::ST_CLEAR: begin
            mem_we     = 1'b1;
            clr_row_in = clr_row_ff + RW'(1);
            if (clr_row_ff == lsugm_pkg::ROW_LAST) begin
               state_in = lsugm_pkg::ST_RUN;
            end
         end
         lsugm_pkg::ST_RUN: begin
            if (q_valid && out_free) begin
               q_pop                  = 1'b1;
               a0_in                  = addr[1:0];
               rsp_in.load_valid      = 1'b0;
               rsp_in.load_data       = 32'd0;
               rsp_in.writeback_valid = 1'b0;
               rsp_in.writeback_value = 32'd0;
               if (in_mem) begin
                  rsp_in.status = lsugm_pkg::STATUS_MEM;
               end else if (is_rb || is_pin) begin
                  rsp_in.status = lsugm_pkg::STATUS_GPIO;
               end else begin
                  rsp_in.status = lsugm_pkg::STATUS_OOB;
               end
               if ((in_mem || is_rb || is_pin) && !q_op.pre) begin
                  rsp_in.writeback_valid = 1'b1;
                  rsp_in.writeback_value = q_op.sum;
               end
               if (in_mem && q_op.is_load) begin
                  // word comes back from the lanes next cycle
                  mem_re   = 1'b1;
                  state_in = lsugm_pkg::ST_READ;
               end else begin
                  mem_we       = in_mem;
                  rsp_valid_in = 1'b1;
                  if (!in_mem && q_op.is_load && (is_rb || is_pin)) begin
                     rsp_in.load_valid = 1'b1;
                     rsp_in.load_data  = is_rb ? addr : 32'd0;
                  end
               end
            end
         end
         lsugm_pkg::ST_READ: begin
            rsp_in.load_valid = 1'b1;
            rsp_in.load_data  = rd_pair[31:0];
            rsp_valid_in      = 1'b1;
            state_in          = lsugm_pkg::ST_RUN;
         end
         default: begin
            state_in = lsugm_pkg::ST_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= lsugm_pkg::ST_CLEAR;
         clr_row_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_row_ff   <= clr_row_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
      a0_ff  <= a0_in;
   end

   // byte lanes: one row address per lane, shared by read and write
   for (genvar k = 0; k < 4; k++) begin : g_lane
      logic [7:0]    lane_mem [lsugm_pkg::MEM_ROWS];
      logic [7:0]    rdat_ff;
      logic [RW-1:0] lane_row;
      logic [7:0]    lane_wdat;

      always_comb begin
         if (state_ff == lsugm_pkg::ST_CLEAR) begin
            lane_row  = clr_row_ff;
            lane_wdat = 8'd0;
         end else begin
            lane_row  = (2'(k) < addr[1:0]) ? row_next : row_base;
            lane_wdat = wr_word[8*k +: 8];
         end
      end

      always_ff @(posedge clock) begin
         if (mem_we) begin
            lane_mem[lane_row] <= lane_wdat;
         end
         if (mem_re) begin
            rdat_ff <= lane_mem[lane_row];
         end
      end

      assign lane_rdat[k] = rdat_ff;
   end

   assign clear_done = (state_ff != lsugm_pkg::ST_CLEAR);
   assign rsp_valid  = rsp_valid_ff;
   assign rsp        = rsp_ff;

endmodule
